### sv/btgl_pkg.sv
`timescale 1ns / 1ps

package btgl_pkg;

    // Width of the cursor registers; the destination ports carry its low 16 bits.
    localparam int COORD_BITS = 16;
    // Working width for cursor arithmetic, wide enough for COORD_BITS plus a step.
    localparam int WIDE_BITS  = 34;

    localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
    localparam logic [7:0] CHAR_SPACE      = 8'd32;
    localparam logic [7:0] CHAR_FIRST_DRAW = 8'd33;
    localparam logic [6:0] ATLAS_BASE      = 7'd32;

    localparam int IDX_BITS = 7;
    localparam int DIV_BITS = 8;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_GLYPH_W       = 3'd2,
        CFG_GLYPH_H       = 3'd3,
        CFG_ADVANCE_W     = 3'd4,
        CFG_ADVANCE_H     = 3'd5,
        CFG_ATLAS_COLUMNS = 3'd6,
        CFG_LAST_PRINT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_text;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] src_x;
        logic        [15:0] src_y;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
    } t_out_item;

    typedef struct packed {
        logic [IDX_BITS-1:0] quot;
        logic [DIV_BITS-1:0] rem;
    } t_div_result;

    localparam logic signed [WIDE_BITS-1:0] COORD_MAX =
        WIDE_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN = -COORD_MAX - WIDE_BITS'(1);

    // Clamps a wide signed value into the signed cursor range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] res;
        if (v > COORD_MAX) begin
            res = COORD_MAX[COORD_BITS-1:0];
        end else if (v < COORD_MIN) begin
            res = COORD_MIN[COORD_BITS-1:0];
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] ext_coord(
        input logic signed [COORD_BITS-1:0] c
    );
        return {{(WIDE_BITS - COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] ext_origin(
        input logic signed [15:0] o
    );
        return {{(WIDE_BITS - 16){o[15]}}, o};
    endfunction

endpackage

### sv/bitmap_text_glyph_layout_unit.sv
`timescale 1ns / 1ps
// Bitmap text glyph layout unit.
// Input channel (i_in_valid, o_in_stall, i_in_data): one character per transfer,
// with a start mark that reloads the cursor from the origin registers first.
// Output channel (o_out_valid, i_out_stall, o_out_data): one result per printable
// character, giving the atlas tile position and the screen position to draw it.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready and is meant to be written while the unit is idle.
// Newline, space and ignored codes are finished in the cycle they are accepted.
// A printable character splits its atlas index by the column count on a restoring
// divider (seven steps, one quotient bit per cycle), then scales column and row
// by the glyph size on one shared 7x8 multiplier, column before row. The next
// character is taken only once the result is in the output register and the
// unit is back to idle, since input is stalled while a glyph is in flight.
// If the receiver stalls, the finished result waits in the output register; a
// new character may be accepted meanwhile, and its result waits until the
// register is free. Reset restores the register defaults and a zero cursor.
// The cursor saturates at the signed COORD_BITS limits.

module bitmap_text_glyph_layout_unit
    import btgl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MULX = 5'b00100,
        S_MULY = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Configuration registers.
    logic signed [15:0] r_origin_x, r_origin_y;
    logic [7:0]         r_glyph_w, r_glyph_h;
    logic [9:0]         r_advance_w, r_advance_h;
    logic [7:0]         r_atlas_columns;
    logic [6:0]         r_last_print;

    // Cursor and job state.
    t_state                       r_state, n_state;
    logic signed [COORD_BITS-1:0] r_cursor_x, n_cursor_x;
    logic signed [COORD_BITS-1:0] r_cursor_y, n_cursor_y;
    logic signed [15:0]           r_dst_x, r_dst_y;
    logic [IDX_BITS-1:0]          r_col, r_row;
    logic [15:0]                  r_src_x, r_src_y;
    logic                         r_out_valid;
    t_out_item                    r_out_data;

    logic                         accept;
    logic                         is_newline, is_space, is_draw;
    logic signed [COORD_BITS-1:0] cur_x_eff, cur_y_eff, org_x_sat;
    logic signed [COORD_BITS-1:0] add_op, add_sum;
    logic [9:0]                   add_inc;
    logic [IDX_BITS-1:0]          atlas_idx;
    logic [DIV_BITS-1:0]          divisor;
    logic                         div_done;
    t_div_result                  div_res;
    logic [IDX_BITS-1:0]          mul_a;
    logic [7:0]                   mul_b;
    logic [14:0]                  mul_p;
    logic signed [WIDE_BITS-1:0]  cur_x_wide, cur_y_wide;
    logic                         out_free;

    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_glyph_w       <= 8'd8;
            r_glyph_h       <= 8'd8;
            r_advance_w     <= 10'd8;
            r_advance_h     <= 10'd8;
            r_atlas_columns <= 8'd16;
            r_last_print    <= 7'd126;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data;
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data;
                CFG_GLYPH_W:       r_glyph_w       <= i_cfg_data[7:0];
                CFG_GLYPH_H:       r_glyph_h       <= i_cfg_data[7:0];
                CFG_ADVANCE_W:     r_advance_w     <= i_cfg_data[9:0];
                CFG_ADVANCE_H:     r_advance_h     <= i_cfg_data[9:0];
                CFG_ATLAS_COLUMNS: r_atlas_columns <= i_cfg_data[7:0];
                CFG_LAST_PRINT:    r_last_print    <= i_cfg_data[6:0];
            endcase
        end
    end

    // Character decode. Items are taken only while no glyph is in flight.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        is_newline = (i_in_data.char_code == CHAR_NEWLINE);
        is_space   = (i_in_data.char_code == CHAR_SPACE);
        is_draw    = (i_in_data.char_code >= CHAR_FIRST_DRAW) &&
                     (i_in_data.char_code <= {1'b0, r_last_print});
        atlas_idx  = i_in_data.char_code[IDX_BITS-1:0] - ATLAS_BASE;
        divisor    = (r_atlas_columns == '0) ? 8'd1 : r_atlas_columns;
    end

    // The cursor after an optional start reload, and the one saturating adder
    // shared by newline (y step) and space or glyph (x step).
    always_comb begin
        org_x_sat = sat_coord(ext_origin(r_origin_x));
        cur_x_eff = i_in_data.start_text ? org_x_sat : r_cursor_x;
        cur_y_eff = i_in_data.start_text ? sat_coord(ext_origin(r_origin_y)) : r_cursor_y;
        add_op    = is_newline ? cur_y_eff : cur_x_eff;
        add_inc   = is_newline ? r_advance_h : r_advance_w;
        add_sum   = sat_coord(ext_coord(add_op) + WIDE_BITS'(add_inc));
        cur_x_wide = ext_coord(cur_x_eff);
        cur_y_wide = ext_coord(cur_y_eff);
    end

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        if (accept) begin
            n_cursor_x = cur_x_eff;
            n_cursor_y = cur_y_eff;
            if (is_newline) begin
                n_cursor_x = org_x_sat;
                n_cursor_y = add_sum;
            end else if (is_space || is_draw) begin
                n_cursor_x = add_sum;
            end
        end
    end

    btgl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && is_draw),
        .i_dividend (atlas_idx),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_result   (div_res)
    );

    // Shared tile multiplier: column by glyph width, then row by glyph height.
    always_comb begin
        mul_a = (r_state == S_MULY) ? r_row : r_col;
        mul_b = (r_state == S_MULY) ? r_glyph_h : r_glyph_w;
        mul_p = {8'd0, mul_a} * {7'd0, mul_b};
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && is_draw) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_MULX;
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job payload: the destination is the cursor before this glyph's advance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dst_x <= cur_x_wide[15:0];
            r_dst_y <= cur_y_wide[15:0];
        end
        if (r_state == S_DIV && div_done) begin
            r_col <= div_res.rem[IDX_BITS-1:0];
            r_row <= div_res.quot;
        end
        if (r_state == S_MULX) begin
            r_src_x <= {1'b0, mul_p};
        end
        if (r_state == S_MULY) begin
            r_src_y <= {1'b0, mul_p};
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data.src_x <= r_src_x;
            r_out_data.src_y <= r_src_y;
            r_out_data.dst_x <= r_dst_x;
            r_out_data.dst_y <= r_dst_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/btgl_div.sv
`timescale 1ns / 1ps

module btgl_div
    import btgl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IDX_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0] i_divisor,
    output logic                o_done,
    output t_div_result         o_result
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_div_state;

    t_div_state          r_state, n_state;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_done, n_done;
    logic [IDX_BITS-1:0] r_dvd, n_dvd;
    logic [DIV_BITS-1:0] r_rem, n_rem;
    logic [DIV_BITS-1:0] r_dvs, n_dvs;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS:0]   diff;
    logic                fits;

    // One restoring step per cycle; the dividend register fills up with quotient bits.
    always_comb begin
        trial = {r_rem, r_dvd[IDX_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_dvd   = i_dividend;
                    n_dvs   = i_divisor;
                    n_rem   = '0;
                    n_cnt   = 3'(IDX_BITS - 1);
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_rem = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
                n_dvd = {r_dvd[IDX_BITS-2:0], fits};
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done          = r_done;
    assign o_result.quot   = r_dvd;
    assign o_result.rem    = r_rem;

endmodule

### sim/tb_bitmap_text_glyph_layout_unit.sv
`timescale 1ns / 1ps

module tb_bitmap_text_glyph_layout_unit;
    import btgl_pkg::*;

    // The run is stopped as failed if it is still going after this many cycles.
    // The slowest correct run is roughly 1200 items times (the work on one item,
    // the longest sender gap and the longest receiver stall), plus the settling
    // pauses around each group of register writes.
    localparam int CYCLE_LIMIT = 600000;
    // Cycles to let pass after the last expected result before registers are
    // written or the run ends.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 11;
    localparam int ITEMS_PER_PHASE = 100;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    bitmap_text_glyph_layout_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the layout registers, held at their field widths.
    logic signed [15:0] org_x = 16'sd0;
    logic signed [15:0] org_y = 16'sd0;
    logic [7:0] tile_w = 8'd8;
    logic [7:0] tile_h = 8'd8;
    logic [9:0] step_w = 10'd8;
    logic [9:0] step_h = 10'd8;
    logic [7:0] atlas_cols = 8'd16;
    logic [6:0] last_code = 7'd126;

    // Shadow copy of the text cursor.
    logic signed [15:0] pen_x = 16'sd0;
    logic signed [15:0] pen_y = 16'sd0;

    t_in_item  char_queue[$];
    t_out_item placement_queue[$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  send_idle = 1'b0;
    bit  recv_idle = 1'b0;
    logic in_fire = 1'b0;

    logic      glyph_drawn;
    t_out_item glyph_place;
    t_out_item placement_want;

    // Gap lengths: mostly none or a few cycles, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Moves a cursor coordinate forward by a step and clamps it to the largest
    // signed 16-bit value. Steps are never negative, so only the top can clip.
    function automatic logic signed [15:0] advance_sat(
        input logic signed [15:0] base,
        input logic [9:0]         step
    );
        logic signed [17:0] sum;
        sum = {{2{base[15]}}, base} + {8'd0, step};
        if (sum > 18'sd32767) return 16'sh7fff;
        return sum[15:0];
    endfunction

    // Applies one character to the shadow cursor and works out the placement
    // that it yields, if any.
    function automatic void layout_char(
        input  t_in_item  item,
        output logic      drawn,
        output t_out_item place
    );
        int idx;
        int cols;
        drawn = 1'b0;
        place = '0;
        if (item.start_text) begin
            pen_x = org_x;
            pen_y = org_y;
        end
        if (item.char_code == CHAR_NEWLINE) begin
            pen_x = org_x;
            pen_y = advance_sat(pen_y, step_h);
        end else if (item.char_code == CHAR_SPACE) begin
            pen_x = advance_sat(pen_x, step_w);
        end else if (item.char_code >= CHAR_FIRST_DRAW &&
                     item.char_code <= {1'b0, last_code}) begin
            idx  = int'(item.char_code) - int'(ATLAS_BASE);
            // A column count of zero behaves like a single column.
            cols = (atlas_cols == 8'd0) ? 1 : int'(atlas_cols);
            place.src_x = 16'((idx % cols) * int'(tile_w));
            place.src_y = 16'((idx / cols) * int'(tile_h));
            place.dst_x = pen_x;
            place.dst_y = pen_y;
            pen_x = advance_sat(pen_x, step_w);
            drawn = 1'b1;
        end
    endfunction

    task automatic flag_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        if (mismatch_count < 10) begin
            $display("[%0d] %s: expected src=(%0d,%0d) dst=(%0d,%0d),",
                     cycle_count, what, want.src_x, want.src_y, want.dst_x, want.dst_y,
                     " got src=(%0d,%0d) dst=(%0d,%0d)",
                     got.src_x, got.src_y, got.dst_x, got.dst_y);
        end
        mismatch_count++;
    endtask

    // Input driver. A character stays on the bus until a transfer takes it;
    // after each transfer the driver may hold off for a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // Still waiting for the unit to take the current character.
        end else if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
            i_in_data  <= char_queue.pop_front();
            i_in_valid <= 1'b1;
            send_gap   <= send_idle ? gap_len() : 0;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output stall generator. Stalls come in runs of random length; in phases
    // with receiver idling switched off the receiver always takes results.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (recv_idle && $urandom_range(0, 3) == 0) begin
            stall_left  <= gap_len();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor. Every character transfer feeds the shadow layout, and every
    // result transfer is checked against the oldest expected placement.
    always @(posedge i_clk) begin
        cycle_count++;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                layout_char(i_in_data, glyph_drawn, glyph_place);
                if (glyph_drawn) begin
                    placement_queue.push_back(glyph_place);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (placement_queue.size() == 0) begin
                    flag_mismatch("result with no glyph pending", '0, o_out_data);
                end else begin
                    placement_want = placement_queue.pop_front();
                    if (o_out_data.src_x !== placement_want.src_x ||
                        o_out_data.src_y !== placement_want.src_y ||
                        o_out_data.dst_x !== placement_want.dst_x ||
                        o_out_data.dst_y !== placement_want.dst_y) begin
                        flag_mismatch("placement differs", placement_want, o_out_data);
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write over the configuration channel. The shadow copy takes the
    // same bits that the unit keeps for each register.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ORIGIN_X:      org_x = value;
            CFG_ORIGIN_Y:      org_y = value;
            CFG_GLYPH_W:       tile_w = value[7:0];
            CFG_GLYPH_H:       tile_h = value[7:0];
            CFG_ADVANCE_W:     step_w = value[9:0];
            CFG_ADVANCE_H:     step_h = value[9:0];
            CFG_ATLAS_COLUMNS: atlas_cols = value[7:0];
            CFG_LAST_PRINT:    last_code = value[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_char(input int code, input bit start);
        t_in_item item;
        item.char_code  = 8'(code);
        item.start_text = start;
        char_queue.push_back(item);
    endtask

    // Waits until every queued character has been taken and every expected
    // placement has arrived, then lets the unit settle.
    task automatic drain();
        @(posedge i_clk);
        while (char_queue.size() > 0 || i_in_valid || placement_queue.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random register values. Most are moderate so that text runs for a while
    // before the cursor clips; extremes and out-of-range settings come up too.
    // The unused upper data bits carry random noise.
    task automatic random_config();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'($urandom_range(0, 65535));
            default: v = 16'($signed($urandom_range(0, 800)) - 400);
        endcase
        write_reg(CFG_ORIGIN_X, v);
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7f00;
            2: v = 16'($urandom_range(0, 65535));
            default: v = 16'($signed($urandom_range(0, 800)) - 400);
        endcase
        write_reg(CFG_ORIGIN_Y, v);
        v = {8'($urandom), ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                                       : 8'($urandom_range(1, 255))};
        write_reg(CFG_GLYPH_W, v);
        v = {8'($urandom), ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 255)
                                                       : 8'($urandom_range(1, 255))};
        write_reg(CFG_GLYPH_H, v);
        v = {6'($urandom), ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                                       : 10'($urandom_range(0, 40))};
        write_reg(CFG_ADVANCE_W, v);
        v = {6'($urandom), ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                                       : 10'($urandom_range(0, 40))};
        write_reg(CFG_ADVANCE_H, v);
        case ($urandom_range(0, 7))
            0: v = {8'($urandom), 8'd0};
            1: v = {8'($urandom), 8'd1};
            2: v = {8'($urandom), 8'($urandom_range(129, 255))};
            default: v = {8'($urandom), 8'($urandom_range(1, 128))};
        endcase
        write_reg(CFG_ATLAS_COLUMNS, v);
        case ($urandom_range(0, 7))
            0: v = {9'($urandom), 7'($urandom_range(0, 32))};
            1: v = {9'($urandom), 7'd127};
            default: v = {9'($urandom), 7'($urandom_range(33, 126))};
        endcase
        write_reg(CFG_LAST_PRINT, v);
    endtask

    // Text-like stream: mostly printable characters with spaces and line
    // breaks, a start mark now and then, and a sprinkling of arbitrary bytes.
    task automatic random_text(input int count);
        int r;
        bit start;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            start = (n == 0) || ($urandom_range(0, 29) == 0);
            if (r < 72) begin
                push_char($urandom_range(33, 127), start);
            end else if (r < 84) begin
                push_char(CHAR_SPACE, start);
            end else if (r < 92) begin
                push_char(CHAR_NEWLINE, start);
            end else begin
                push_char($urandom_range(0, 255), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults after reset: printable range ends, the first code
        // past the last printable, high bytes, control codes, newline and
        // space, and the start mark combined with each kind of character.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        push_char(65, 1'b0);
        push_char(33, 1'b0);
        push_char(126, 1'b0);
        push_char(127, 1'b0);
        push_char(128, 1'b0);
        push_char(255, 1'b1);
        push_char(0, 1'b0);
        push_char(9, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_char(48, 1'b0);
        push_char(CHAR_NEWLINE, 1'b1);
        push_char(CHAR_SPACE, 1'b1);
        push_char(90, 1'b1);
        drain();

        // Largest settings: the cursor starts at the top of its range and
        // clips on every step, tiles are as large as they get, one column
        // stacks every glyph in a single tall strip, and code 127 is drawn.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_reg(CFG_ORIGIN_X, 16'h7fff);
        write_reg(CFG_ORIGIN_Y, 16'h7ff0);
        write_reg(CFG_GLYPH_W, 16'h00ff);
        write_reg(CFG_GLYPH_H, 16'hffff);
        write_reg(CFG_ADVANCE_W, 16'h03ff);
        write_reg(CFG_ADVANCE_H, 16'hffff);
        write_reg(CFG_ATLAS_COLUMNS, 16'h0001);
        write_reg(CFG_LAST_PRINT, 16'h007f);
        push_char(127, 1'b1);
        push_char(126, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_char(33, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        push_char(64, 1'b0);
        drain();

        // Smallest settings: origin at the bottom of the range, zero sizes so
        // nothing moves, zero columns, and a last code too low to draw anything.
        write_reg(CFG_ORIGIN_X, 16'h8000);
        write_reg(CFG_ORIGIN_Y, 16'h8000);
        write_reg(CFG_GLYPH_W, 16'hff00);
        write_reg(CFG_GLYPH_H, 16'h0000);
        write_reg(CFG_ADVANCE_W, 16'hfc00);
        write_reg(CFG_ADVANCE_H, 16'h0000);
        write_reg(CFG_ATLAS_COLUMNS, 16'h0000);
        write_reg(CFG_LAST_PRINT, 16'hff80 | 16'd32);
        push_char(65, 1'b1);
        push_char(33, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        drain();
        // The lowest drawable last code, with the column count of zero in use.
        write_reg(CFG_LAST_PRINT, 16'd33);
        push_char(33, 1'b1);
        push_char(34, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        drain();

        // Random settings, each followed by a stretch of random text. Idling
        // on either side is switched on or off per stretch.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            random_config();
            random_text(ITEMS_PER_PHASE);
            drain();
        end

        mismatch_count += placement_queue.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
